>>> rtl/core/pfc_pkg.sv
// Shared types and constants for the pixel format converter.
// No dependencies; used by pixel_format_converter_top.
package pfc_pkg;

    // Conversion mode codes held in the mode register.
    typedef enum logic [2:0] {
        MODE_GRAY        = 3'd0,
        MODE_THRESH      = 3'd1,
        MODE_THRESH_PACK = 3'd2,
        MODE_PACK        = 3'd3,
        MODE_UNPACK      = 3'd4
    } mode_t;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_WIDTH = 2'd1;
    localparam logic [1:0] CFG_MAXV  = 2'd2;

    // Fixed field widths.
    localparam int ImgWidthW = 14;

    // Luma weights: 0.299, 0.587 and 0.114 in 16 fraction bits.
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

endpackage

>>> rtl/core/pixel_format_converter_top.sv
// Pixel format converter: luma, threshold, bit packing and bit unpacking.
// An item's first result is registered and shows in the cycle after it is taken.
// Throughput: 1 item per cycle in modes 0 to 3 unless the output stalls; in mode 4
//   an item holds the result register until it has given all its bits (up to 8).
// Reset: rst_n is asynchronous and active low; it clears all state but the result
//   value and loads the register defaults (mode 0, width 1, max value 255).
// Depends on pfc_pkg.
module pixel_format_converter_top #(
    parameter int MAX_WIDTH = 16383
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input item channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample,
    // Result item channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] out_value,
    output logic        last,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // The column counter only needs to reach the effective row width, which
    // is bounded both by MAX_WIDTH and by the 14-bit width register.
    localparam int RawColW = $clog2(MAX_WIDTH + 1);
    localparam int ColW = (RawColW < pfc_pkg::ImgWidthW) ? RawColW : pfc_pkg::ImgWidthW;

    // ------------------------------------------------------------------
    // Configuration registers. The port always takes a write; writes to an
    // index beyond the register list are dropped.
    // ------------------------------------------------------------------
    logic [2:0]  mode_reg;
    logic [13:0] img_width_reg;
    logic [15:0] max_value_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg      <= pfc_pkg::MODE_GRAY;
            img_width_reg <= 14'd1;
            max_value_reg <= 16'd255;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pfc_pkg::CFG_MODE:  mode_reg      <= cfg_data[2:0];
                pfc_pkg::CFG_WIDTH: img_width_reg <= cfg_data[13:0];
                pfc_pkg::CFG_MAXV:  max_value_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Processing state. Instead of holding raw red and green samples, the
    // luma sum is accumulated as each channel arrives, so only one constant
    // multiplier and one add sit in front of the result register. The
    // weights sum to 65536, so the sum always fits in 32 bits.
    // ------------------------------------------------------------------
    logic [1:0]      chan_reg,  chan_next;
    logic [31:0]     acc_reg,   acc_next;
    logic [ColW-1:0] col_reg,   col_next;
    logic [7:0]      pbyte_reg, pbyte_next;
    logic [2:0]      bits_reg,  bits_next;

    // Result register. For an unpacked byte it holds the byte, the number of
    // bits to give and the index of the bit currently shown.
    logic        res_valid_reg, res_valid_next;
    logic        res_unpack_reg, res_unpack_next;
    logic [15:0] res_value_reg, res_value_next;
    logic [3:0]  res_cnt_reg, res_cnt_next;
    logic [2:0]  res_idx_reg, res_idx_next;

    logic in_fire;
    logic out_fire;
    logic res_final;

    assign out_valid = res_valid_reg;
    assign out_fire  = out_valid && !out_stall;
    assign last      = res_unpack_reg ? (({1'b0, res_idx_reg} + 4'd1) == res_cnt_reg) : 1'b1;
    assign res_final = last;
    assign out_value = res_unpack_reg ? {15'd0, res_value_reg[3'd7 - res_idx_reg]}
                                      : res_value_reg;

    // A new item is taken whenever the result register is empty or its last
    // result leaves in this cycle, so items flow back to back.
    assign in_stall = res_valid_reg && !(out_fire && res_final);
    assign in_fire  = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Datapath terms.
    // ------------------------------------------------------------------
    logic            clamp_width;
    logic [ColW-1:0] eff_width;
    logic [ColW-1:0] col_start;
    logic [16:0]     thresh_lim;
    logic            thr_bit;
    logic            pack_bit;
    logic [7:0]      pb_shift;
    logic [ColW-1:0] col_inc;
    logic            row_end;
    logic [7:0]      pad_val;
    logic [ColW-1:0] left;
    logic [3:0]      un_cnt;
    logic [ColW-1:0] col_un;
    logic [15:0]     coef;
    logic [31:0]     product;
    logic [31:0]     luma_sum;

    always_comb begin
        // Width 0 acts as 1; widths above MAX_WIDTH are clamped.
        clamp_width = {3'd0, img_width_reg} > 17'(MAX_WIDTH);
        if (img_width_reg == 14'd0) begin
            eff_width = ColW'(1);
        end
        else if (clamp_width) begin
            eff_width = ColW'(MAX_WIDTH);
        end
        else begin
            eff_width = ColW'(img_width_reg);
        end

        // A column left beyond the row, for example after the width was
        // lowered, restarts the row.
        col_start = (col_reg >= eff_width) ? '0 : col_reg;

        thresh_lim = ({1'b0, max_value_reg} + 17'd1) >> 1;
        thr_bit    = ({1'b0, sample} <= thresh_lim);
        pack_bit   = (mode_reg == pfc_pkg::MODE_THRESH_PACK) ? thr_bit : sample[0];

        pb_shift = {pbyte_reg[6:0], pack_bit};
        col_inc  = col_start + ColW'(1);
        row_end  = (col_inc >= eff_width);
        // Partial byte at row end: left-justify and fill the low side with ones.
        pad_val  = (pb_shift << (3'd7 - bits_reg)) | (8'hFF >> ({1'b0, bits_reg} + 4'd1));

        left   = eff_width - col_start;
        un_cnt = (left < ColW'(8)) ? left[3:0] : 4'd8;
        col_un = col_start + ColW'(un_cnt);

        unique case (chan_reg)
            2'd1:    coef = pfc_pkg::COEF_G;
            2'd2:    coef = pfc_pkg::COEF_B;
            default: coef = pfc_pkg::COEF_R;
        endcase
        product  = 32'(sample) * 32'(coef);
        luma_sum = ((chan_reg == 2'd1) || (chan_reg == 2'd2)) ? acc_reg + product : product;
    end

    // ------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------
    always_comb begin
        chan_next       = chan_reg;
        acc_next        = acc_reg;
        col_next        = col_reg;
        pbyte_next      = pbyte_reg;
        bits_next       = bits_reg;
        res_valid_next  = res_valid_reg;
        res_unpack_next = res_unpack_reg;
        res_value_next  = res_value_reg;
        res_cnt_next    = res_cnt_reg;
        res_idx_next    = res_idx_reg;

        // Retire the shown result or step to the next unpacked bit.
        if (out_fire) begin
            if (res_final) begin
                res_valid_next = 1'b0;
            end
            else begin
                res_idx_next = res_idx_reg + 3'd1;
            end
        end

        if (in_fire) begin
            case (mode_reg)
                pfc_pkg::MODE_GRAY: begin
                    acc_next = luma_sum;
                    if (chan_reg == 2'd1) begin
                        chan_next = 2'd2;
                    end
                    else if (chan_reg == 2'd2) begin
                        chan_next       = 2'd0;
                        res_valid_next  = 1'b1;
                        res_unpack_next = 1'b0;
                        res_value_next  = luma_sum[31:16];
                    end
                    else begin
                        chan_next = 2'd1;
                    end
                end
                pfc_pkg::MODE_THRESH: begin
                    res_valid_next  = 1'b1;
                    res_unpack_next = 1'b0;
                    res_value_next  = {15'd0, thr_bit};
                end
                pfc_pkg::MODE_THRESH_PACK, pfc_pkg::MODE_PACK: begin
                    col_next = row_end ? '0 : col_inc;
                    if (bits_reg == 3'd7) begin
                        // Byte complete; a row ending here needs no pad byte.
                        res_valid_next  = 1'b1;
                        res_unpack_next = 1'b0;
                        res_value_next  = {8'd0, pb_shift};
                        pbyte_next      = 8'd0;
                        bits_next       = 3'd0;
                    end
                    else if (row_end) begin
                        res_valid_next  = 1'b1;
                        res_unpack_next = 1'b0;
                        res_value_next  = {8'd0, pad_val};
                        pbyte_next      = 8'd0;
                        bits_next       = 3'd0;
                    end
                    else begin
                        pbyte_next = pb_shift;
                        bits_next  = bits_reg + 3'd1;
                    end
                end
                pfc_pkg::MODE_UNPACK: begin
                    col_next        = (col_un >= eff_width) ? '0 : col_un;
                    res_valid_next  = 1'b1;
                    res_unpack_next = 1'b1;
                    res_value_next  = {8'd0, sample[7:0]};
                    res_cnt_next    = un_cnt;
                    res_idx_next    = 3'd0;
                end
                default: ;  // Unused modes drop the item and keep the state.
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            chan_reg       <= 2'd0;
            acc_reg        <= 32'd0;
            col_reg        <= '0;
            pbyte_reg      <= 8'd0;
            bits_reg       <= 3'd0;
            res_valid_reg  <= 1'b0;
            res_unpack_reg <= 1'b0;
            res_cnt_reg    <= 4'd1;
            res_idx_reg    <= 3'd0;
        end
        else begin
            chan_reg       <= chan_next;
            acc_reg        <= acc_next;
            col_reg        <= col_next;
            pbyte_reg      <= pbyte_next;
            bits_reg       <= bits_next;
            res_valid_reg  <= res_valid_next;
            res_unpack_reg <= res_unpack_next;
            res_cnt_reg    <= res_cnt_next;
            res_idx_reg    <= res_idx_next;
        end
    end

    always_ff @(posedge clk) begin
        res_value_reg <= res_value_next;
    end

`ifndef SYNTHESIS
    // The bit being shown always lies inside the unpacked run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_unpack_reg) |-> ({1'b0, res_idx_reg} < res_cnt_reg))
        else $error("unpack bit index beyond its count");

    // An unpacked run gives between one and eight bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_unpack_reg) |-> (res_cnt_reg != 4'd0 && res_cnt_reg <= 4'd8))
        else $error("unpack count out of range");

    // No item is taken while an unpacked run still has bits to give.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_unpack_reg && !last) |-> !in_fire)
        else $error("item accepted during an unpack run");

    // The channel sequence never reaches the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        chan_reg != 2'd3)
        else $error("stray luma channel index");

    // A result that is held back stays in place across the stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_value) && $stable(last)))
        else $error("stalled result changed");
`endif

endmodule

>>> sim/tb_pixel_format_converter_top.sv
// Self-checking bench for pixel_format_converter_top: luma, threshold, packing and unpacking.
// Each result is checked against a bit-true software copy of the converter.
// Depends on pfc_pkg and pixel_format_converter_top.
`timescale 1ns / 1ps

module tb_pixel_format_converter_top;

    localparam int MAX_W = 16383;

    // Mode codes that the converter must ignore.
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

    // Cycles of forced output stall used to back the converter up.
    localparam int LONG_HOLD = 64;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } pix_result_t;

    // One line of the directed table: either a register write or a pixel item.
    // For pixel items a hand-written value may be given for the single result.
    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [15:0] data;
        logic        typed;
        logic [15:0] want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] sample = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] out_value;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Side tags that travel with the item on the input so that the checker
    // can pick up a hand-written value at the same edge as the item.
    logic        tag_on = 1'b0;
    logic [15:0] tag_value = '0;

    // Request from the stimulus for a long output stall.
    logic        hold_req = 1'b0;

    // Software copy of the converter: registers and state.
    logic [2:0]  mode_q = pfc_pkg::MODE_GRAY;
    logic [13:0] width_q = 14'd1;
    logic [15:0] maxv_q = 16'd255;
    logic [1:0]  chan_q = '0;
    logic [15:0] red_q = '0;
    logic [15:0] green_q = '0;
    logic [13:0] col_q = '0;
    logic [7:0]  pbyte_q = '0;
    logic [3:0]  nbits_q = '0;

    pix_result_t pending_pixels[$];

    int bad_pixels = 0;
    int results_seen = 0;
    int pixels_sent = 0;
    int send_pct = 0;
    int recv_pct = 0;
    int hold_left = 0;

    row_t steps [0:40];

    pixel_format_converter_top #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .sample(sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_value(out_value),
        .last(last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // A width of zero behaves as one pixel per row; widths above MAX_W are clamped to it.
    function automatic int row_width();
        int w;
        w = (width_q == 0) ? 1 : int'(width_q);
        if (w > MAX_W)
        begin
            w = MAX_W;
        end
        return w;
    endfunction

    // The threshold is (max_value+1)/2, worked out in int so the sum cannot wrap.
    function automatic logic thresh_bit(input logic [15:0] s);
        return (int'(s) <= (int'(maxv_q) + 1) / 2);
    endfunction

    // Shift one bit into the byte being packed. A full byte goes out at once;
    // a row that ends on a partial byte pads it with ones on the low side.
    function automatic void pack_bit(input logic b);
        int w;
        int fill;
        w = row_width();
        if (col_q >= w)
        begin
            col_q = '0;
        end
        pbyte_q = {pbyte_q[6:0], b};
        nbits_q = nbits_q + 1'b1;
        col_q = col_q + 1'b1;
        if (nbits_q >= 8)
        begin
            pending_pixels.push_back('{value: {8'h00, pbyte_q}, last: 1'b1});
            pbyte_q = '0;
            nbits_q = '0;
        end
        if (col_q >= w)
        begin
            if (nbits_q > 0)
            begin
                fill = 8 - int'(nbits_q);
                pending_pixels.push_back('{value: {8'h00,
                    8'((int'(pbyte_q) << fill) | ((1 << fill) - 1))}, last: 1'b1});
                pbyte_q = '0;
                nbits_q = '0;
            end
            col_q = '0;
        end
    endfunction

    // Works out the results one accepted item gives and queues them in order.
    function automatic void convert_sample(input logic [15:0] s);
        longint unsigned acc;
        int w;
        int cnt;
        case (mode_q)
            pfc_pkg::MODE_GRAY:
            begin
                if (chan_q == 2'd1)
                begin
                    green_q = s;
                    chan_q = 2'd2;
                end
                else if (chan_q == 2'd2)
                begin
                    acc = 64'(pfc_pkg::COEF_R) * 64'(red_q)
                        + 64'(pfc_pkg::COEF_G) * 64'(green_q)
                        + 64'(pfc_pkg::COEF_B) * 64'(s);
                    pending_pixels.push_back('{value: acc[31:16], last: 1'b1});
                    chan_q = 2'd0;
                end
                else
                begin
                    red_q = s;
                    chan_q = 2'd1;
                end
            end
            pfc_pkg::MODE_THRESH:
            begin
                pending_pixels.push_back('{value: {15'd0, thresh_bit(s)}, last: 1'b1});
            end
            pfc_pkg::MODE_THRESH_PACK:
            begin
                pack_bit(thresh_bit(s));
            end
            pfc_pkg::MODE_PACK:
            begin
                pack_bit(s[0]);
            end
            pfc_pkg::MODE_UNPACK:
            begin
                w = row_width();
                if (col_q >= w)
                begin
                    col_q = '0;
                end
                cnt = (w - int'(col_q) < 8) ? w - int'(col_q) : 8;
                for (int k = 0; k < cnt; k++)
                begin
                    pending_pixels.push_back('{value: {15'd0, s[7 - k]},
                                               last: (k + 1 == cnt)});
                end
                col_q = 14'(int'(col_q) + cnt);
                if (col_q >= w)
                begin
                    col_q = '0;
                end
            end
            default:
            begin
                // The unused modes drop the item and leave the state alone.
            end
        endcase
    endfunction

    // One process does all the checking and all the modelling, so the order in
    // which it sees results, register writes and new items in the same cycle is fixed.
    // It also drives the output stall, including the long hold-off.
    always @(posedge clk)
    begin
        pix_result_t exp_pix;
        int before_n;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_pixels.size() == 0)
                begin
                    bad_pixels++;
                    if (bad_pixels <= 10)
                    begin
                        $display("result %0d: nothing pending, got value %h last %b",
                                 results_seen, out_value, last);
                    end
                end
                else
                begin
                    exp_pix = pending_pixels.pop_front();
                    if (out_value !== exp_pix.value)
                    begin
                        bad_pixels++;
                        if (bad_pixels <= 10)
                        begin
                            $display("result %0d: out_value expected %h got %h",
                                     results_seen, exp_pix.value, out_value);
                        end
                    end
                    if (last !== exp_pix.last)
                    begin
                        bad_pixels++;
                        if (bad_pixels <= 10)
                        begin
                            $display("result %0d: last expected %b got %b",
                                     results_seen, exp_pix.last, last);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pfc_pkg::CFG_MODE:  mode_q = cfg_data[2:0];
                    pfc_pkg::CFG_WIDTH: width_q = cfg_data[13:0];
                    pfc_pkg::CFG_MAXV:  maxv_q = cfg_data;
                    default:   ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                before_n = pending_pixels.size();
                convert_sample(sample);
                // A hand-written value replaces the computed one for that item.
                if (tag_on && pending_pixels.size() > before_n)
                begin
                    pending_pixels[$].value = tag_value;
                end
            end
        end
        if (hold_req)
        begin
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    // Drops valid and waits until every queued result has been taken, then
    // waits on for items that are still being worked on but give no result.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Register writes only go in while the converter is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Offers one item and returns at the edge that takes it, leaving valid high
    // so that a following item can go out back to back.
    task automatic send_pixel(input logic [15:0] s, input logic typed,
                              input logic [15:0] want);
        // The idle pattern moves through three phases as the run goes on:
        // a sluggish receiver, then a sluggish sender, then full speed.
        if (pixels_sent < 127)
        begin
            send_pct = 28;
            recv_pct = 85;
        end
        else if (pixels_sent < 254)
        begin
            send_pct = 85;
            recv_pct = 28;
        end
        else
        begin
            send_pct = 0;
            recv_pct = 0;
        end
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        tag_on <= typed;
        tag_value <= want;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pixels_sent++;
    endtask

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int counted;
        int n;
        int thr;
        logic [2:0] m;
        logic [13:0] w;
        logic [15:0] mv;
        logic [15:0] s;

        // Directed part. Hand-written values are given where the answer is plain:
        // all-ones luma, threshold edges, and padded bytes.
        steps = '{
            // Luma from reset state: full-scale channels give full-scale gray.
            '{ROW_PIX, '0, 16'hFFFF, 1'b0, '0},
            '{ROW_PIX, '0, 16'hFFFF, 1'b0, '0},
            '{ROW_PIX, '0, 16'hFFFF, 1'b1, 16'hFFFF},
            // Red only, then a mode change in the middle of the pixel.
            '{ROW_PIX, '0, 16'h0007, 1'b0, '0},
            '{ROW_CFG, pfc_pkg::CFG_MODE, {13'd0, pfc_pkg::MODE_THRESH}, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0080, 1'b1, 16'h0001},
            '{ROW_PIX, '0, 16'h0081, 1'b1, 16'h0000},
            // Back to luma: the held red carries over.
            '{ROW_CFG, pfc_pkg::CFG_MODE, {13'd0, pfc_pkg::MODE_GRAY}, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0009, 1'b0, '0},
            '{ROW_PIX, '0, 16'h001E, 1'b0, '0},
            // Zero max value puts the threshold at zero.
            '{ROW_CFG, pfc_pkg::CFG_MAXV, 16'h0000, 1'b0, '0},
            '{ROW_CFG, pfc_pkg::CFG_MODE, {13'd0, pfc_pkg::MODE_THRESH}, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0000, 1'b1, 16'h0001},
            '{ROW_PIX, '0, 16'h0001, 1'b1, 16'h0000},
            // Largest max value: threshold at 32768.
            '{ROW_CFG, pfc_pkg::CFG_MAXV, 16'hFFFF, 1'b0, '0},
            '{ROW_PIX, '0, 16'h8000, 1'b1, 16'h0001},
            '{ROW_PIX, '0, 16'hFFFF, 1'b1, 16'h0000},
            // Threshold and pack a 3-pixel row: 101 padded with ones.
            '{ROW_CFG, pfc_pkg::CFG_MODE, {13'd0, pfc_pkg::MODE_THRESH_PACK}, 1'b0, '0},
            '{ROW_CFG, pfc_pkg::CFG_WIDTH, 16'd3, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0000, 1'b0, '0},
            '{ROW_PIX, '0, 16'hFFFF, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0005, 1'b1, 16'h00BF},
            // Width zero behaves as one pixel: a lone zero bit and seven ones.
            '{ROW_CFG, pfc_pkg::CFG_MODE, {13'd0, pfc_pkg::MODE_PACK}, 1'b0, '0},
            '{ROW_CFG, pfc_pkg::CFG_WIDTH, 16'd0, 1'b0, '0},
            '{ROW_PIX, '0, 16'hFFFE, 1'b1, 16'h007F},
            // Width lowered below the current column restarts the row.
            '{ROW_CFG, pfc_pkg::CFG_WIDTH, 16'd5, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0001, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0003, 1'b0, '0},
            '{ROW_CFG, pfc_pkg::CFG_WIDTH, 16'd2, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0000, 1'b0, '0},
            '{ROW_PIX, '0, 16'h0001, 1'b0, '0},
            // Unpack: a full byte, then a short row end, then the widest row.
            '{ROW_CFG, pfc_pkg::CFG_MODE, {13'd0, pfc_pkg::MODE_UNPACK}, 1'b0, '0},
            '{ROW_CFG, pfc_pkg::CFG_WIDTH, 16'd11, 1'b0, '0},
            '{ROW_PIX, '0, 16'h00A5, 1'b0, '0},
            '{ROW_PIX, '0, 16'hFF5A, 1'b0, '0},
            '{ROW_CFG, pfc_pkg::CFG_WIDTH, 16'h3FFF, 1'b0, '0},
            '{ROW_PIX, '0, 16'hFFFF, 1'b0, '0},
            // Unused modes swallow items.
            '{ROW_CFG, pfc_pkg::CFG_MODE, {13'd0, MODE_UNUSED_LO}, 1'b0, '0},
            '{ROW_PIX, '0, 16'h1234, 1'b0, '0},
            '{ROW_CFG, pfc_pkg::CFG_MODE, {13'd0, MODE_UNUSED_HI}, 1'b0, '0},
            '{ROW_PIX, '0, 16'hABCD, 1'b0, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].kind == ROW_CFG)
            begin
                write_reg(steps[i].idx, steps[i].data);
            end
            else
            begin
                send_pixel(steps[i].data, steps[i].typed, steps[i].want);
            end
        end

        // Random part, in phases of one register setting each. Items in the
        // unused modes do not count toward the total.
        counted = 0;
        for (int phase = 0; counted < 355; phase++)
        begin
            if ($urandom_range(0, 19) < 18)
            begin
                m = 3'($urandom_range(pfc_pkg::MODE_GRAY, pfc_pkg::MODE_UNPACK));
            end
            else
            begin
                m = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            end
            case ($urandom_range(0, 7))
                0: w = 14'd0;
                1: w = 14'd1;
                2: w = 14'h3FFF;
                3: w = 14'd8;
                4: w = 14'd16;
                default: w = 14'($urandom_range(2, 20));
            endcase
            case ($urandom_range(0, 5))
                0: mv = 16'h0000;
                1: mv = 16'hFFFF;
                2: mv = 16'h0001;
                3: mv = 16'h00FF;
                default: mv = 16'($urandom);
            endcase
            // The second phase unpacks into the widest row so that every item
            // gives eight results; the long output stall there backs the
            // converter up until it stalls its input.
            if (phase == 1)
            begin
                m = pfc_pkg::MODE_UNPACK;
                w = 14'h3FFF;
            end
            // Unused upper bits of the write data are set at random.
            write_reg(pfc_pkg::CFG_MODE, {13'($urandom), m});
            write_reg(pfc_pkg::CFG_WIDTH, {2'($urandom), w});
            write_reg(pfc_pkg::CFG_MAXV, mv);
            if (phase == 1)
            begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end

            n = (m > pfc_pkg::MODE_UNPACK) ? 4 : $urandom_range(20, 34);
            thr = (int'(mv) + 1) / 2;
            for (int k = 0; k < n; k++)
            begin
                case ($urandom_range(0, 7))
                    0: s = 16'h0000;
                    1: s = 16'hFFFF;
                    2, 3: s = 16'(thr + $urandom_range(0, 2) - 1);
                    default: s = 16'($urandom);
                endcase
                send_pixel(s, 1'b0, '0);
                if (m <= pfc_pkg::MODE_UNPACK)
                begin
                    counted++;
                end
                // Now and then the sender stops until the output side is empty.
                if (phase % 3 == 2 && k == n / 2)
                begin
                    settle();
                end
            end
        end

        settle();
        if (bad_pixels == 0 && pending_pixels.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/pfc_pkg.sv
rtl/core/pixel_format_converter_top.sv
sim/tb_pixel_format_converter_top.sv
